>>> hw/rtl/vnff_pkg.sv
// Shared types and constants for the vertex normal unit.
package vnff_pkg;

   localparam int MAX_FACES_DEF = 64;
   localparam int COORD_W       = 24;
   localparam int EDGE_W        = COORD_W + 1;
   localparam int MUL_W         = 31;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int VEC_W         = 50;
   localparam int NORM_W        = 30;
   localparam int ROOT_W        = 31;
   localparam int SREM_W        = ROOT_W + 2;
   localparam int NUM_W         = NORM_W + 15;
   localparam int DREM_W        = ROOT_W;
   localparam int Q_W           = 15;
   localparam int N_W           = 16;
   localparam int CNT_W         = 5;
   localparam int IN_DATA_W     = 9 * COORD_W;
   localparam int OUT_DATA_W    = 3 * N_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CROSS,
      ST_LOADMAG,
      ST_NORM,
      ST_ZERO,
      ST_SQUARE,
      ST_SQINIT,
      ST_SQRT,
      ST_DIVINIT,
      ST_DIVIDE,
      ST_ACCUM,
      ST_LOADSUM,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_CROSS,
      MUL_SQUARE
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_CROSS,
      ACC_SQUARE
   } acc_op_type;

   typedef struct packed {
      logic       take;
      mul_op_type mul_op;
      logic [2:0] mul_idx;
      acc_op_type acc_op;
      logic [2:0] acc_idx;
      logic       load_mag;
      logic       norm_step;
      logic       zero_q;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       accum;
      logic       set_ovf;
      logic       load_sum;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic mag_zero;
      logic in_range;
      logic out_free;
   } status_type;

endpackage

>>> hw/rtl/vnff_ctrl.sv
// Sequencer for the vertex normal unit: steps one triangle through the datapath.
module vnff_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  vnff_pkg::status_type status,
   output vnff_pkg::cmd_type    cmd
);

   vnff_pkg::state_type             state_ff, state_in;
   logic [vnff_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            final_ff, final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vnff_pkg::ST_IDLE;
         cnt_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         final_ff <= final_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      final_in = final_ff;
      case (state_ff)
         vnff_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) state_in = vnff_pkg::ST_CHECK;
         end
         vnff_pkg::ST_CHECK: begin
            cnt_in = '0;
            if (status.full) begin
               state_in = status.last ? vnff_pkg::ST_LOADSUM : vnff_pkg::ST_IDLE;
            end else begin
               state_in = vnff_pkg::ST_CROSS;
            end
         end
         vnff_pkg::ST_CROSS: begin
            if (cnt_ff == vnff_pkg::CNT_W'(6)) state_in = vnff_pkg::ST_LOADMAG;
         end
         vnff_pkg::ST_LOADMAG: begin
            state_in = vnff_pkg::ST_NORM;
         end
         vnff_pkg::ST_NORM: begin
            cnt_in = '0;
            if (status.mag_zero) state_in = vnff_pkg::ST_ZERO;
            else if (status.in_range) state_in = vnff_pkg::ST_SQUARE;
         end
         vnff_pkg::ST_ZERO: begin
            state_in = final_ff ? vnff_pkg::ST_EMIT : vnff_pkg::ST_ACCUM;
         end
         vnff_pkg::ST_SQUARE: begin
            if (cnt_ff == vnff_pkg::CNT_W'(3)) state_in = vnff_pkg::ST_SQINIT;
         end
         vnff_pkg::ST_SQINIT: begin
            cnt_in   = '0;
            state_in = vnff_pkg::ST_SQRT;
         end
         vnff_pkg::ST_SQRT: begin
            if (cnt_ff == vnff_pkg::CNT_W'(vnff_pkg::ROOT_W - 1)) begin
               state_in = vnff_pkg::ST_DIVINIT;
            end
         end
         vnff_pkg::ST_DIVINIT: begin
            cnt_in   = '0;
            state_in = vnff_pkg::ST_DIVIDE;
         end
         vnff_pkg::ST_DIVIDE: begin
            if (cnt_ff == vnff_pkg::CNT_W'(vnff_pkg::Q_W - 1)) begin
               state_in = final_ff ? vnff_pkg::ST_EMIT : vnff_pkg::ST_ACCUM;
            end
         end
         vnff_pkg::ST_ACCUM: begin
            state_in = status.last ? vnff_pkg::ST_LOADSUM : vnff_pkg::ST_IDLE;
         end
         vnff_pkg::ST_LOADSUM: begin
            final_in = 1'b1;
            state_in = vnff_pkg::ST_LOADMAG;
         end
         vnff_pkg::ST_EMIT: begin
            if (status.out_free) begin
               final_in = 1'b0;
               state_in = vnff_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vnff_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         vnff_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         vnff_pkg::ST_CHECK: begin
            cmd.set_ovf = status.full;
         end
         vnff_pkg::ST_CROSS: begin
            if (cnt_ff < vnff_pkg::CNT_W'(6)) begin
               cmd.mul_op  = vnff_pkg::MUL_CROSS;
               cmd.mul_idx = cnt_ff[2:0];
            end
            if (cnt_ff != '0) begin
               cmd.acc_op  = vnff_pkg::ACC_CROSS;
               cmd.acc_idx = 3'(cnt_ff - 1'b1);
            end
         end
         vnff_pkg::ST_LOADMAG: begin
            cmd.load_mag = 1'b1;
         end
         vnff_pkg::ST_NORM: begin
            cmd.norm_step = !status.mag_zero && !status.in_range;
         end
         vnff_pkg::ST_ZERO: begin
            cmd.zero_q = 1'b1;
         end
         vnff_pkg::ST_SQUARE: begin
            if (cnt_ff < vnff_pkg::CNT_W'(3)) begin
               cmd.mul_op  = vnff_pkg::MUL_SQUARE;
               cmd.mul_idx = cnt_ff[2:0];
            end
            if (cnt_ff != '0) begin
               cmd.acc_op  = vnff_pkg::ACC_SQUARE;
               cmd.acc_idx = 3'(cnt_ff - 1'b1);
            end
         end
         vnff_pkg::ST_SQINIT: begin
            cmd.sqrt_init = 1'b1;
         end
         vnff_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
         end
         vnff_pkg::ST_DIVINIT: begin
            cmd.div_init = 1'b1;
         end
         vnff_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         vnff_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         vnff_pkg::ST_LOADSUM: begin
            cmd.load_sum = 1'b1;
         end
         vnff_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/vnff_dpath.sv
// Datapath: edges, shared multiplier, normalize, square root, dividers, sums, result register.
module vnff_dpath #(
   parameter int MAX_FACES = vnff_pkg::MAX_FACES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [vnff_pkg::IN_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vnff_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   input  vnff_pkg::cmd_type                  cmd,
   output vnff_pkg::status_type               status
);

   localparam int SUM_W   = $clog2(MAX_FACES) + 16;
   localparam int COUNT_W = $clog2(MAX_FACES + 1);
   localparam int EW = vnff_pkg::EDGE_W;
   localparam int CW = vnff_pkg::COORD_W;
   localparam int VW = vnff_pkg::VEC_W;

   logic signed [EW-1:0]                  e0_ff [3];
   logic signed [EW-1:0]                  e1_ff [3];
   logic                                  last_ff;
   logic signed [vnff_pkg::MUL_W-1:0]     mul_a, mul_b;
   logic signed [vnff_pkg::PROD_W-1:0]    prod_ff;
   logic signed [VW-1:0]                  v_ff [3];
   logic [VW-1:0]                         mag_ff [3];
   logic                                  neg_ff [3];
   logic [VW-1:0]                         mag_or;
   logic [vnff_pkg::PROD_W-1:0]           sq_ff;
   logic [vnff_pkg::PROD_W-1:0]           sreg_ff;
   logic [vnff_pkg::ROOT_W-1:0]           root_ff;
   logic [vnff_pkg::SREM_W-1:0]           srem_ff;
   logic [vnff_pkg::SREM_W+1:0]           srem2;
   logic [vnff_pkg::SREM_W+1:0]           strial;
   logic [vnff_pkg::DREM_W-1:0]           drem_ff [3];
   logic [vnff_pkg::Q_W-1:0]              dlow_ff [3];
   logic [vnff_pkg::Q_W-1:0]              q_ff [3];
   logic signed [vnff_pkg::N_W-1:0]       n [3];
   logic                                  zero_ff;
   logic signed [SUM_W-1:0]               sum_ff [3];
   logic [COUNT_W-1:0]                    count_ff;
   logic                                  ovf_ff;
   logic                                  rsp_valid_ff;
   logic [vnff_pkg::OUT_DATA_W-1:0]       out_data_ff;
   logic [1:0]                            out_user_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         vnff_pkg::MUL_CROSS: begin
            case (cmd.mul_idx)
               3'd0: begin mul_a = 31'(e0_ff[1]); mul_b = 31'(e1_ff[2]); end
               3'd1: begin mul_a = 31'(e0_ff[2]); mul_b = 31'(e1_ff[1]); end
               3'd2: begin mul_a = 31'(e0_ff[2]); mul_b = 31'(e1_ff[0]); end
               3'd3: begin mul_a = 31'(e0_ff[0]); mul_b = 31'(e1_ff[2]); end
               3'd4: begin mul_a = 31'(e0_ff[0]); mul_b = 31'(e1_ff[1]); end
               3'd5: begin mul_a = 31'(e0_ff[1]); mul_b = 31'(e1_ff[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         vnff_pkg::MUL_SQUARE: begin
            case (cmd.mul_idx)
               3'd0: mul_a = {1'b0, mag_ff[0][vnff_pkg::NORM_W-1:0]};
               3'd1: mul_a = {1'b0, mag_ff[1][vnff_pkg::NORM_W-1:0]};
               3'd2: mul_a = {1'b0, mag_ff[2][vnff_pkg::NORM_W-1:0]};
               default: mul_a = '0;
            endcase
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign srem2  = {srem_ff, sreg_ff[vnff_pkg::PROD_W-1 -: 2]};
   assign strial = {2'b00, root_ff, 2'b01};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n[i] = neg_ff[i] ? -$signed({1'b0, q_ff[i]}) : $signed({1'b0, q_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         for (int i = 0; i < 3; i++) begin
            e0_ff[i] <= EW'($signed(req_tdata[(3 + i) * CW +: CW]))
                      - EW'($signed(req_tdata[i * CW +: CW]));
            e1_ff[i] <= EW'($signed(req_tdata[(6 + i) * CW +: CW]))
                      - EW'($signed(req_tdata[(3 + i) * CW +: CW]));
         end
         last_ff <= req_tlast;
      end
      if (cmd.mul_op != vnff_pkg::MUL_NONE) prod_ff <= mul_a * mul_b;

      // even steps open a cross component, odd steps subtract
      if (cmd.acc_op == vnff_pkg::ACC_CROSS) begin
         if (cmd.acc_idx[0]) begin
            v_ff[cmd.acc_idx[2:1]] <= v_ff[cmd.acc_idx[2:1]] - prod_ff[VW-1:0];
         end else begin
            v_ff[cmd.acc_idx[2:1]] <= prod_ff[VW-1:0];
         end
      end
      if (cmd.acc_op == vnff_pkg::ACC_SQUARE) begin
         if (cmd.acc_idx == 3'd0) sq_ff <= prod_ff;
         else sq_ff <= sq_ff + prod_ff;
      end
      if (cmd.load_sum) begin
         for (int i = 0; i < 3; i++) v_ff[i] <= VW'(sum_ff[i]);
      end

      if (cmd.load_mag) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= v_ff[i][VW-1];
            mag_ff[i] <= v_ff[i][VW-1] ? (~v_ff[i] + 1'b1) : v_ff[i];
         end
         zero_ff <= 1'b0;
      end
      // coarse steps of eight keep the search short; right shifts drop bits
      if (cmd.norm_step) begin
         for (int i = 0; i < 3; i++) begin
            if (|mag_or[VW-1:37]) mag_ff[i] <= mag_ff[i] >> 8;
            else if (|mag_or[VW-1:30]) mag_ff[i] <= mag_ff[i] >> 1;
            else if (!(|mag_or[VW-1:21])) mag_ff[i] <= mag_ff[i] << 8;
            else mag_ff[i] <= mag_ff[i] << 1;
         end
      end
      if (cmd.zero_q) begin
         for (int i = 0; i < 3; i++) q_ff[i] <= '0;
         zero_ff <= 1'b1;
      end

      if (cmd.sqrt_init) begin
         sreg_ff <= sq_ff;
         root_ff <= '0;
         srem_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         sreg_ff <= sreg_ff << 2;
         if (srem2 >= strial) begin
            srem_ff <= vnff_pkg::SREM_W'(srem2 - strial);
            root_ff <= {root_ff[vnff_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= vnff_pkg::SREM_W'(srem2);
            root_ff <= {root_ff[vnff_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      if (cmd.div_init) begin
         for (int i = 0; i < 3; i++) begin
            logic [vnff_pkg::NUM_W-1:0] num;
            num = {1'b0, mag_ff[i][vnff_pkg::NORM_W-1:0], 14'b0}
                + vnff_pkg::NUM_W'(root_ff >> 1);
            drem_ff[i] <= {1'b0, num[vnff_pkg::NUM_W-1:vnff_pkg::Q_W]};
            dlow_ff[i] <= num[vnff_pkg::Q_W-1:0];
            q_ff[i]    <= '0;
         end
      end
      if (cmd.div_step) begin
         for (int i = 0; i < 3; i++) begin
            logic [vnff_pkg::DREM_W:0] t;
            t = {drem_ff[i], dlow_ff[i][vnff_pkg::Q_W-1]};
            dlow_ff[i] <= dlow_ff[i] << 1;
            if (t >= {1'b0, root_ff}) begin
               drem_ff[i] <= vnff_pkg::DREM_W'(t - {1'b0, root_ff});
               q_ff[i]    <= {q_ff[i][vnff_pkg::Q_W-2:0], 1'b1};
            end else begin
               drem_ff[i] <= t[vnff_pkg::DREM_W-1:0];
               q_ff[i]    <= {q_ff[i][vnff_pkg::Q_W-2:0], 1'b0};
            end
         end
      end

      if (cmd.emit) begin
         out_data_ff <= {n[2], n[1], n[0]};
         out_user_ff <= {ovf_ff, zero_ff};
      end
   end

   // vertex state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            for (int i = 0; i < 3; i++) sum_ff[i] <= sum_ff[i] + SUM_W'(n[i]);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.set_ovf) ovf_ff <= 1'b1;
         if (cmd.emit) begin
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
            count_ff     <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.full     = (count_ff == COUNT_W'(MAX_FACES));
   assign status.last     = last_ff;
   assign status.mag_zero = (mag_or == '0);
   assign status.in_range = !(|mag_or[VW-1:30]) && mag_or[29];
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_FACES))
      else $error("face count past limit");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0) && (sum_ff[0] == '0) && !ovf_ff)
      else $error("vertex state not cleared after result");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> root_ff[vnff_pkg::ROOT_W-1:vnff_pkg::ROOT_W-2] != 2'b00)
      else $error("square root below normalized range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

endmodule

>>> hw/rtl/vertex_normal_from_faces_unit.sv
// Top level of the vertex normal unit: averages unit face normals into a unit vertex normal.
//
//   channel  direction  beat contents
//   req_     in         tdata: three corners a, b, c (x, y, z each); tlast: last face
//   rsp_     out        tdata: normal x, y, z; tuser: degenerate, overflow
//
// A triangle's time is set mostly by a 31-step square root and a 15-step divider (three
// lanes at once), the rest by the shared multiplier and the normalize shifter; a zero
// cross product skips the square root and the divider.
// The last triangle then normalizes the sum the same way, unless the sum is zero; a
// triangle past the face limit only sets the overflow flag. Reset clears the sums, count and overflow flag.
// A result waits in the output register; the next triangle is taken meanwhile.
module vertex_normal_from_faces_unit #(
   parameter int MAX_FACES = vnff_pkg::MAX_FACES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (24 bits each)
   input  logic [vnff_pkg::IN_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // normal_x, normal_y, normal_z (16 bits each)
   output logic [vnff_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   // degenerate, overflow
   output logic [1:0]                        rsp_tuser
);

   vnff_pkg::cmd_type    cmd;
   vnff_pkg::status_type status;

   vnff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vnff_dpath #(
      .MAX_FACES (MAX_FACES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> tb/sv/tb.sv
// Testbench for the vertex normal unit: random triangle runs checked against a local predictor.
`timescale 1ns / 100ps

class normal_scoreboard;
   typedef struct {
      logic [15:0] nx, ny, nz;
      logic        degen, ovf;
   } normal_type;

   longint sum_x, sum_y, sum_z;
   int     face_count;
   bit     overflow_seen;
   normal_type pending[$];
   int     mismatches;

   function new();
      sum_x = 0; sum_y = 0; sum_z = 0; face_count = 0; overflow_seen = 0;
      mismatches = 0;
   endfunction

   static function longint int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scale to Q1.14 unit length; returns 0 for the zero vector.
   static function bit unit_scale(input longint v[3], output longint n[3]);
      longint unsigned mag[3], m, s, r, q;
      bit neg[3];
      m = 0; s = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         n[0] = 0; n[1] = 0; n[2] = 0;
         return 0;
      end
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + (r >> 1)) / r;
         n[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function void note_face(logic [215:0] data, logic last);
      longint c[9], cr[3], fn[3], sv[3], vn[3];
      longint e0x, e0y, e0z, e1x, e1y, e1z;
      bit ok;
      normal_type res;
      for (int i = 0; i < 9; i++) c[i] = longint'($signed(data[i*24 +: 24]));
      e0x = c[3] - c[0]; e0y = c[4] - c[1]; e0z = c[5] - c[2];
      e1x = c[6] - c[3]; e1y = c[7] - c[4]; e1z = c[8] - c[5];
      if (face_count >= 64) begin
         overflow_seen = 1;
      end else begin
         cr[0] = e0y * e1z - e0z * e1y;
         cr[1] = e0z * e1x - e0x * e1z;
         cr[2] = e0x * e1y - e0y * e1x;
         void'(unit_scale(cr, fn));
         sum_x += fn[0]; sum_y += fn[1]; sum_z += fn[2];
         face_count++;
      end
      if (!last) return;
      sv[0] = sum_x; sv[1] = sum_y; sv[2] = sum_z;
      ok = unit_scale(sv, vn);
      res.nx = vn[0][15:0]; res.ny = vn[1][15:0]; res.nz = vn[2][15:0];
      res.degen = !ok;
      res.ovf = overflow_seen;
      pending = {pending, res};
      sum_x = 0; sum_y = 0; sum_z = 0; face_count = 0; overflow_seen = 0;
   endfunction

   function void check_normal(logic [47:0] data, logic [1:0] user);
      normal_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h %b", data, user);
         return;
      end
      e = pending.pop_front();
      if (data !== {e.nz, e.ny, e.nx} || user !== {e.ovf, e.degen}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("normal mismatch: exp %h %h %h deg %b ovf %b, got %h %h %h user %b",
                     e.nx, e.ny, e.nz, e.degen, e.ovf,
                     data[15:0], data[31:16], data[47:32], user);
      end
   endfunction
endclass

module tb;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [215:0] req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [47:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   normal_scoreboard sb = new();
   int  idle_cycles = 0;

   localparam int WATCHDOG = 20000;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   vertex_normal_from_faces_unit u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_face(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_normal(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("vertex_normal_from_faces_unit regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls between beats.
   initial begin
      int w;
      @(posedge clock iff !reset);
      forever begin
         w = $urandom_range(0, 3);
         if (w > 0) begin
            rsp_tready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock iff rsp_tvalid);
      end
   end

   function automatic logic [23:0] rand_coord(int mode);
      case (mode)
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 511)) - 24'd256;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_face(logic [215:0] d, logic last);
      int w;
      w = $urandom_range(0, 3);
      if (w > 0) begin
         req_tvalid <= 0;
         repeat (w) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      req_tlast  <= last;
      @(posedge clock iff req_tready);
   endtask

   task automatic send_random_vertex(int faces);
      logic [215:0] d;
      int mode;
      for (int f = 0; f < faces; f++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++) begin
            if (mode == 0) d[i*24 +: 24] = (i < 3) ? 24'h123456 : rand_coord(3);
            else if (mode == 1) d[i*24 +: 24] = rand_coord($urandom_range(0, 1));
            else if (mode < 5) d[i*24 +: 24] = rand_coord(2);
            else d[i*24 +: 24] = rand_coord(3);
         end
         // Collinear corners give a zero cross product.
         if (mode == 0) d[215:72] = {d[71:0], d[71:0]};
         send_face(d, f == faces - 1);
      end
   endtask

   initial begin
      logic [215:0] d;
      int faces, sent;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Extremes of the coordinate range.
      send_face({9{24'h7FFFFF}}, 1);
      send_face({9{24'h800000}}, 1);
      send_face({{3{24'h800000}}, {3{24'h7FFFFF}}, {3{24'h000000}}}, 1);
      send_face({24'h0, 24'h0, 24'h800000, 24'h0, 24'h7FFFFF, 24'h0,
                 24'h0, 24'h0, 24'h800000}, 1);
      // Unit triangle and its mirror: the sum cancels to zero.
      d = {24'h0, 24'h0, 24'h10000, 24'h0, 24'h10000, 24'h0, 24'h0, 24'h0, 24'h0};
      send_face(d, 1);
      send_face(d, 0);
      send_face({d[215:144], d[71:0], d[143:72]}, 1);
      // Single degenerate triangle.
      send_face({3{24'h000100, 24'h000200, 24'h000300}}, 1);
      // Overflow: more faces than the accumulator limit, and exactly the limit.
      send_random_vertex(66);
      send_random_vertex(64);
      send_random_vertex(65);
      sent = 0;
      while (sent < 1300) begin
         faces = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 6);
         send_random_vertex(faces);
         sent += faces;
      end
      req_tvalid <= 0;
      wait (sb.pending.size() == 0);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0)
         $display("vertex_normal_from_faces_unit regression: pass");
      else
         $display("vertex_normal_from_faces_unit regression: fail");
      $finish;
   end
endmodule
